// ===== src/alarm_clock_with_beep_pattern_assert.svh =====
// Assertion macros for the alarm clock with beep pattern.
`ifndef ALARM_CLOCK_WITH_BEEP_PATTERN_ASSERT_SVH
`define ALARM_CLOCK_WITH_BEEP_PATTERN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACWB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACWB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/acwb_pkg.sv =====
// Package with the payload types, codes, constants and modulo helpers of the alarm clock.
`default_nettype none

package acwb_pkg;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_SET     = 2'd1,
      CMD_SILENCE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_ALARM_HOUR     = 2'd0,
      REG_ALARM_MINUTE   = 2'd1,
      REG_ALARM_DURATION = 2'd2,
      REG_ALARM_ENABLE   = 2'd3
   } reg_index_type;

   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 19;

   localparam logic [15:0] MS_LAST_OF_MINUTE = 16'd59999;
   localparam logic [5:0]  MINUTE_LAST       = 6'd59;
   localparam logic [4:0]  HOUR_LAST         = 5'd23;
   localparam logic [4:0]  HOUR_NOON         = 5'd12;
   localparam logic [3:0]  DISPLAY_TWELVE    = 4'd12;
   localparam logic [18:0] DURATION_MAX      = 19'd300000;
   localparam logic [18:0] DURATION_RESET    = 19'd60000;
   localparam logic [18:0] ELAPSED_MAX       = 19'd524287;
   localparam logic [9:0]  PHASE_LAST        = 10'd999;
   localparam logic [9:0]  PHASE_ON_LIMIT    = 10'd750;
   localparam logic [7:0]  SUBPHASE_LAST     = 8'd149;
   localparam logic [7:0]  SUBPHASE_ON_LIMIT = 8'd75;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] new_hour;
      logic [7:0] new_minute;
      logic       is_delta;
   } req_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [3:0] display_hour;
      logic       is_pm;
      logic       minute_changed;
      logic       alarm_ringing;
      logic       buzzer_on;
   } rsp_type;

   // Reduces a value below 384 modulo 24 by conditional subtraction.
   function automatic logic [4:0] mod_24(input logic [8:0] value);
      logic [8:0] rem;
      rem = value;
      if (rem >= 9'd192) rem = rem - 9'd192;
      if (rem >= 9'd96)  rem = rem - 9'd96;
      if (rem >= 9'd48)  rem = rem - 9'd48;
      if (rem >= 9'd24)  rem = rem - 9'd24;
      return rem[4:0];
   endfunction

   // Reduces a value below 480 modulo 60 by conditional subtraction.
   function automatic logic [5:0] mod_60(input logic [8:0] value);
      logic [8:0] rem;
      rem = value;
      if (rem >= 9'd240) rem = rem - 9'd240;
      if (rem >= 9'd120) rem = rem - 9'd120;
      if (rem >= 9'd60)  rem = rem - 9'd60;
      return rem[5:0];
   endfunction

endpackage

`default_nettype wire

// ===== src/alarm_clock_with_beep_pattern.sv =====
// Top level of the hour and minute clock with alarm and beep pattern.
//
//   Channel   Ports                          Role
//   request   req_valid req_ready req_data   command in (tick, set time, silence)
//   response  rsp_valid rsp_ready rsp_data   time and alarm status after each command
//   csr       csr_we csr_addr csr_wdata      alarm hour, minute, duration and enable
//
// One command is taken in every cycle unless the response side stalls; its result is
// registered and shows in the cycle after the transfer. The clock state and the result
// register update in a single pass. Reset is synchronous; no clearing pass follows it.
// A waiting result stalls the request side only while rsp_ready is low.
`default_nettype none

`include "alarm_clock_with_beep_pattern_assert.svh"

module alarm_clock_with_beep_pattern (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire acwb_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output acwb_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [acwb_pkg::CsrAddrWidth-1:0]   csr_addr,
   input  wire logic [acwb_pkg::CsrDataWidth-1:0]   csr_wdata
);

   logic [4:0]  alarm_hour_ff;
   logic [5:0]  alarm_minute_ff;
   logic [18:0] alarm_duration_ff;
   logic        alarm_enable_ff;

   logic [4:0]  hours_ff,    hours_in;
   logic [5:0]  minutes_ff,  minutes_in;
   logic [15:0] ms_ff,       ms_in;
   logic        ringing_ff,  ringing_in;
   logic [18:0] elapsed_ff,  elapsed_in;
   logic [9:0]  phase_ff,    phase_in;
   logic [7:0]  subphase_ff, subphase_in;

   logic              rsp_valid_ff;
   acwb_pkg::rsp_type rsp_data_ff, rsp_in;

   logic        req_accept;
   logic        changed;
   logic        try_start;
   logic [4:0]  hour_half;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      hours_in    = hours_ff;
      minutes_in  = minutes_ff;
      ms_in       = ms_ff;
      ringing_in  = ringing_ff;
      elapsed_in  = elapsed_ff;
      phase_in    = phase_ff;
      subphase_in = subphase_ff;
      changed     = 1'b0;
      try_start   = 1'b0;
      case (req_data.cmd)
         acwb_pkg::CMD_TICK: begin
            if (ringing_ff) begin
               if (elapsed_ff != acwb_pkg::ELAPSED_MAX) begin
                  elapsed_in = elapsed_ff + 19'd1;
               end
               if (phase_ff >= acwb_pkg::PHASE_LAST) begin
                  phase_in    = 10'd0;
                  subphase_in = 8'd0;
               end else begin
                  phase_in = phase_ff + 10'd1;
                  if (subphase_ff >= acwb_pkg::SUBPHASE_LAST) begin
                     subphase_in = 8'd0;
                  end else begin
                     subphase_in = subphase_ff + 8'd1;
                  end
               end
            end
            if (ms_ff >= acwb_pkg::MS_LAST_OF_MINUTE) begin
               ms_in     = 16'd0;
               changed   = 1'b1;
               try_start = 1'b1;
               if (minutes_ff >= acwb_pkg::MINUTE_LAST) begin
                  minutes_in = 6'd0;
                  hours_in   = (hours_ff >= acwb_pkg::HOUR_LAST) ? 5'd0 : hours_ff + 5'd1;
               end else begin
                  minutes_in = minutes_ff + 6'd1;
               end
            end else begin
               ms_in = ms_ff + 16'd1;
            end
         end
         acwb_pkg::CMD_SET: begin
            if (req_data.is_delta) begin
               hours_in   = acwb_pkg::mod_24({4'd0, hours_ff} + {1'b0, req_data.new_hour});
               minutes_in = acwb_pkg::mod_60({3'd0, minutes_ff} + {1'b0, req_data.new_minute});
            end else begin
               hours_in   = acwb_pkg::mod_24({1'b0, req_data.new_hour});
               minutes_in = acwb_pkg::mod_60({1'b0, req_data.new_minute});
            end
            ms_in     = 16'd0;
            try_start = 1'b1;
         end
         acwb_pkg::CMD_SILENCE: begin
            ringing_in  = 1'b0;
            elapsed_in  = 19'd0;
            phase_in    = 10'd0;
            subphase_in = 8'd0;
         end
         default: begin
         end
      endcase
      if (try_start && alarm_enable_ff && !ringing_in && hours_in == alarm_hour_ff &&
          minutes_in == alarm_minute_ff) begin
         ringing_in  = 1'b1;
         elapsed_in  = 19'd0;
         phase_in    = 10'd0;
         subphase_in = 8'd0;
      end
      if (req_data.cmd == acwb_pkg::CMD_TICK && ringing_in &&
          elapsed_in > alarm_duration_ff) begin
         ringing_in  = 1'b0;
         elapsed_in  = 19'd0;
         phase_in    = 10'd0;
         subphase_in = 8'd0;
      end
   end

   always_comb begin
      hour_half             = (hours_in >= acwb_pkg::HOUR_NOON) ?
                              hours_in - acwb_pkg::HOUR_NOON : hours_in;
      rsp_in.hour           = hours_in;
      rsp_in.minute         = minutes_in;
      rsp_in.display_hour   = (hour_half == 5'd0) ? acwb_pkg::DISPLAY_TWELVE : hour_half[3:0];
      rsp_in.is_pm          = hours_in >= acwb_pkg::HOUR_NOON;
      rsp_in.minute_changed = changed;
      rsp_in.alarm_ringing  = ringing_in;
      rsp_in.buzzer_on      = ringing_in && phase_in <= acwb_pkg::PHASE_ON_LIMIT &&
                              subphase_in <= acwb_pkg::SUBPHASE_ON_LIMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_hour_ff     <= 5'd0;
         alarm_minute_ff   <= 6'd0;
         alarm_duration_ff <= acwb_pkg::DURATION_RESET;
         alarm_enable_ff   <= 1'b0;
         hours_ff          <= 5'd0;
         minutes_ff        <= 6'd0;
         ms_ff             <= 16'd0;
         ringing_ff        <= 1'b0;
         elapsed_ff        <= 19'd0;
         phase_ff          <= 10'd0;
         subphase_ff       <= 8'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (req_accept) begin
            hours_ff     <= hours_in;
            minutes_ff   <= minutes_in;
            ms_ff        <= ms_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && (csr_addr != acwb_pkg::REG_ALARM_ENABLE || !csr_wdata[0])) begin
            ringing_ff  <= 1'b0;
            elapsed_ff  <= 19'd0;
            phase_ff    <= 10'd0;
            subphase_ff <= 8'd0;
         end else if (req_accept) begin
            ringing_ff  <= ringing_in;
            elapsed_ff  <= elapsed_in;
            phase_ff    <= phase_in;
            subphase_ff <= subphase_in;
         end
         if (csr_we) begin
            case (csr_addr)
               acwb_pkg::REG_ALARM_HOUR: begin
                  alarm_hour_ff <= csr_wdata[4:0];
               end
               acwb_pkg::REG_ALARM_MINUTE: begin
                  alarm_minute_ff <= csr_wdata[5:0];
               end
               acwb_pkg::REG_ALARM_DURATION: begin
                  alarm_duration_ff <= (csr_wdata > acwb_pkg::DURATION_MAX) ?
                                       acwb_pkg::DURATION_MAX : csr_wdata;
               end
               acwb_pkg::REG_ALARM_ENABLE: begin
                  alarm_enable_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   `ACWB_ASSERT_SAME(a_idle_counters_zero, !ringing_ff,
      elapsed_ff == 19'd0 && phase_ff == 10'd0 && subphase_ff == 8'd0,
      "ring counters are not zero while the alarm is idle")
   `ACWB_ASSERT_SAME(a_ms_in_range, 1'b1, ms_ff <= acwb_pkg::MS_LAST_OF_MINUTE,
      "millisecond counter left its range")
   `ACWB_ASSERT_SAME(a_minute_change_restarts_ms, rsp_valid_ff && rsp_data_ff.minute_changed,
      ms_ff == 16'd0, "minute change reported without the millisecond counter restarting")
   `ACWB_ASSERT_NEXT(a_csr_stops_ring,
      csr_we && (csr_addr != acwb_pkg::REG_ALARM_ENABLE || !csr_wdata[0]),
      !ringing_ff, "alarm still ringing after a register write that stops it")
   `ACWB_ASSERT_NEXT(a_drain_empties, rsp_valid_ff && rsp_ready && !req_accept,
      !rsp_valid_ff, "result register still full after its transfer")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the alarm clock: queued commands, predicted status, field compare.
module tb;

   localparam logic [1:0] CMD_UNUSED       = 2'd3;
   localparam int         HOURS_PER_DAY    = 24;
   localparam int         MINUTES_PER_HOUR = 60;
   localparam int         HALF_DAY         = 12;
   localparam int         GAP_MAX          = 8;
   localparam int         STALL_MAX        = 10;
   localparam int         RANDOM_PHASES    = 6;
   localparam int         PHASE_ITEMS      = 100;
   localparam int         CYCLE_LIMIT      = 4000000;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   acwb_pkg::req_type                 req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   acwb_pkg::rsp_type                 rsp_data;
   logic                              csr_we    = 1'b0;
   logic [acwb_pkg::CsrAddrWidth-1:0] csr_addr  = '0;
   logic [acwb_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   logic [4:0]  now_hour;
   logic [5:0]  now_minute;
   logic [15:0] ms_count;
   logic        bell_on;
   logic [18:0] bell_ms;
   logic [9:0]  bell_phase;
   logic [7:0]  bell_sub;
   logic [4:0]  wake_hour;
   logic [5:0]  wake_minute;
   logic [18:0] ring_limit;
   logic        wake_armed;

   acwb_pkg::req_type cmd_backlog[$];
   acwb_pkg::rsp_type status_due[$];

   logic req_fired    = 1'b0;
   int   gap_left     = 0;
   int   burst_left   = 0;
   int   stall_left   = 0;
   int   calm_left    = 0;
   int   cmds_queued  = 0;
   int   cmds_sent    = 0;
   int   results_seen = 0;
   int   mismatches   = 0;
   int   minute_steps = 0;
   int   ring_starts  = 0;
   int   cycle_count  = 0;

   alarm_clock_with_beep_pattern DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic logic rand_bit();
      logic [31:0] r;
      r = $urandom;
      return r[0];
   endfunction

   function automatic void silence_bell();
      bell_on    = 1'b0;
      bell_ms    = '0;
      bell_phase = '0;
      bell_sub   = '0;
   endfunction

   function automatic void arm_check();
      if (wake_armed && !bell_on && now_hour == wake_hour && now_minute == wake_minute) begin
         bell_on    = 1'b1;
         bell_ms    = '0;
         bell_phase = '0;
         bell_sub   = '0;
         ring_starts++;
      end
   endfunction

   function automatic void reset_clock_model();
      wake_hour   = '0;
      wake_minute = '0;
      ring_limit  = acwb_pkg::DURATION_RESET;
      wake_armed  = 1'b0;
      now_hour    = '0;
      now_minute  = '0;
      ms_count    = '0;
      silence_bell();
   endfunction

   task automatic advance_clock_model(input acwb_pkg::req_type cmd_in,
                                      output acwb_pkg::rsp_type status);
      logic [31:0] hour_sum;
      logic [31:0] minute_sum;
      logic        stepped;
      stepped = 1'b0;
      case (cmd_in.cmd)
         acwb_pkg::CMD_TICK: begin
            if (bell_on) begin
               if (bell_ms != acwb_pkg::ELAPSED_MAX) bell_ms = bell_ms + 19'd1;
               bell_phase = bell_phase + 10'd1;
               bell_sub   = bell_sub + 8'd1;
               if (bell_phase > acwb_pkg::PHASE_LAST) begin
                  bell_phase = '0;
                  bell_sub   = '0;
               end else if (bell_sub > acwb_pkg::SUBPHASE_LAST) begin
                  bell_sub = '0;
               end
            end
            if (ms_count == acwb_pkg::MS_LAST_OF_MINUTE) begin
               ms_count = '0;
               if (now_minute == acwb_pkg::MINUTE_LAST) begin
                  now_minute = '0;
                  now_hour   = (now_hour == acwb_pkg::HOUR_LAST) ? 5'd0 : now_hour + 5'd1;
               end else begin
                  now_minute = now_minute + 6'd1;
               end
               stepped = 1'b1;
               minute_steps++;
               arm_check();
            end else begin
               ms_count = ms_count + 16'd1;
            end
            if (bell_on && bell_ms > ring_limit) silence_bell();
         end
         acwb_pkg::CMD_SET: begin
            hour_sum   = {24'd0, cmd_in.new_hour};
            minute_sum = {24'd0, cmd_in.new_minute};
            if (cmd_in.is_delta) begin
               hour_sum   = hour_sum + {27'd0, now_hour};
               minute_sum = minute_sum + {26'd0, now_minute};
            end
            hour_sum   = hour_sum % HOURS_PER_DAY;
            minute_sum = minute_sum % MINUTES_PER_HOUR;
            now_hour   = hour_sum[4:0];
            now_minute = minute_sum[5:0];
            ms_count   = '0;
            arm_check();
         end
         acwb_pkg::CMD_SILENCE: silence_bell();
         default: ;
      endcase
      hour_sum = {27'd0, now_hour} % HALF_DAY;
      status                = '0;
      status.hour           = now_hour;
      status.minute         = now_minute;
      status.display_hour   = (hour_sum == 0) ? acwb_pkg::DISPLAY_TWELVE : hour_sum[3:0];
      status.is_pm          = (now_hour >= acwb_pkg::HOUR_NOON);
      status.minute_changed = stepped;
      status.alarm_ringing  = bell_on;
      status.buzzer_on      = bell_on && bell_phase <= acwb_pkg::PHASE_ON_LIMIT &&
                              bell_sub <= acwb_pkg::SUBPHASE_ON_LIMIT;
   endtask

   function automatic void check_field(input string name, input logic [18:0] want,
                                       input logic [18:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] hour_val,
                            input logic [7:0] minute_val, input logic delta);
      acwb_pkg::req_type item;
      item.cmd        = cmd;
      item.new_hour   = hour_val;
      item.new_minute = minute_val;
      item.is_delta   = delta;
      cmd_backlog.push_back(item);
      cmds_queued++;
   endtask

   task automatic queue_ticks(input int count);
      for (int i = 0; i < count; i++)
         queue_cmd(acwb_pkg::CMD_TICK, rand_byte(), rand_byte(), rand_bit());
   endtask

   task automatic queue_alarm_match(input logic [31:0] ah, input logic [31:0] am,
                                    input logic use_delta);
      logic [31:0] th;
      logic [31:0] tm;
      logic [31:0] hv;
      logic [31:0] mv;
      if (use_delta) begin
         th = $urandom_range(0, HOURS_PER_DAY - 1);
         tm = $urandom_range(0, MINUTES_PER_HOUR - 1);
         queue_cmd(acwb_pkg::CMD_SET, th[7:0], tm[7:0], 1'b0);
         hv = (ah + HOURS_PER_DAY - th) % HOURS_PER_DAY + HOURS_PER_DAY * $urandom_range(0, 9);
         mv = (am + MINUTES_PER_HOUR - tm) % MINUTES_PER_HOUR +
              MINUTES_PER_HOUR * $urandom_range(0, 3);
      end else begin
         hv = ah;
         mv = am;
         if (ah < HOURS_PER_DAY)
            hv = ah + HOURS_PER_DAY * $urandom_range(0, (255 - ah) / HOURS_PER_DAY);
         if (am < MINUTES_PER_HOUR)
            mv = am + MINUTES_PER_HOUR * $urandom_range(0, (255 - am) / MINUTES_PER_HOUR);
      end
      queue_cmd(acwb_pkg::CMD_SET, hv[7:0], mv[7:0], use_delta);
   endtask

   task automatic write_reg(input acwb_pkg::reg_index_type idx,
                            input logic [acwb_pkg::CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         acwb_pkg::REG_ALARM_HOUR: begin
            wake_hour = value[4:0];
            silence_bell();
         end
         acwb_pkg::REG_ALARM_MINUTE: begin
            wake_minute = value[5:0];
            silence_bell();
         end
         acwb_pkg::REG_ALARM_DURATION: begin
            ring_limit = (value > acwb_pkg::DURATION_MAX) ? acwb_pkg::DURATION_MAX : value;
            silence_bell();
         end
         acwb_pkg::REG_ALARM_ENABLE: begin
            wake_armed = value[0];
            if (!value[0]) silence_bell();
         end
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (cmd_backlog.size() != 0 || req_valid || status_due.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fired)) begin
         req_fired = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (cmd_backlog.size() != 0) begin
            req_data  <= cmd_backlog.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, GAP_MAX);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (calm_left != 0) begin
         calm_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(0, STALL_MAX - 1);
         rsp_ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 300);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      acwb_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (status_due.size() == 0) begin
               $error("Result transfer with no command waiting for it");
               mismatches++;
            end else begin
               want = status_due.pop_front();
               check_field("hour", 19'(want.hour), 19'(rsp_data.hour));
               check_field("minute", 19'(want.minute), 19'(rsp_data.minute));
               check_field("display_hour", 19'(want.display_hour),
                           19'(rsp_data.display_hour));
               check_field("is_pm", 19'(want.is_pm), 19'(rsp_data.is_pm));
               check_field("minute_changed", 19'(want.minute_changed),
                           19'(rsp_data.minute_changed));
               check_field("alarm_ringing", 19'(want.alarm_ringing),
                           19'(rsp_data.alarm_ringing));
               check_field("buzzer_on", 19'(want.buzzer_on), 19'(rsp_data.buzzer_on));
            end
         end
         if (req_valid && req_ready) begin
            advance_clock_model(req_data, want);
            status_due.push_back(want);
            cmds_sent++;
            req_fired = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] ah;
      logic [31:0] am;
      logic [31:0] dur;
      logic [31:0] junk;
      logic [31:0] pick;
      int          phase_end;
      reset_clock_model();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 1'b1);
      queue_cmd(acwb_pkg::CMD_SILENCE, 8'h00, 8'h00, 1'b0);
      queue_cmd(acwb_pkg::CMD_SET, 8'hFF, 8'hFF, 1'b0);
      queue_cmd(acwb_pkg::CMD_SET, 8'hFF, 8'hFF, 1'b1);
      queue_cmd(acwb_pkg::CMD_SET, 8'd0, 8'd0, 1'b0);
      queue_cmd(acwb_pkg::CMD_SET, 8'd12, 8'd0, 1'b0);
      queue_cmd(acwb_pkg::CMD_SET, 8'd11, 8'd59, 1'b0);
      queue_cmd(acwb_pkg::CMD_SET, 8'd23, 8'd59, 1'b0);
      queue_ticks(2);
      wait_idle();

      write_reg(acwb_pkg::REG_ALARM_HOUR, 19'd7);
      write_reg(acwb_pkg::REG_ALARM_MINUTE, 19'd30);
      write_reg(acwb_pkg::REG_ALARM_DURATION, 19'd0);
      write_reg(acwb_pkg::REG_ALARM_ENABLE, 19'd1);
      queue_cmd(acwb_pkg::CMD_SET, 8'd7, 8'd30, 1'b0);
      queue_ticks(1);
      queue_cmd(acwb_pkg::CMD_SET, 8'd0, 8'd0, 1'b1);
      queue_cmd(acwb_pkg::CMD_SET, 8'd24, 8'd60, 1'b1);
      queue_cmd(acwb_pkg::CMD_SILENCE, 8'hA5, 8'h5A, 1'b1);
      queue_cmd(acwb_pkg::CMD_SET, 8'd0, 8'd0, 1'b1);
      wait_idle();
      write_reg(acwb_pkg::REG_ALARM_ENABLE, 19'd0);
      queue_cmd(acwb_pkg::CMD_SET, 8'd7, 8'd30, 1'b0);
      wait_idle();
      write_reg(acwb_pkg::REG_ALARM_ENABLE, 19'd1);
      queue_cmd(acwb_pkg::CMD_SET, 8'd31, 8'd90, 1'b0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         ah = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
         am = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 63) : $urandom_range(0, 59);
         pick = $urandom_range(0, 9);
         if (pick < 4) dur = $urandom_range(0, 150);
         else if (pick < 7) dur = $urandom_range(151, 1200);
         else if (pick < 9) dur = $urandom_range(0, 19'h7FFFF);
         else dur = acwb_pkg::DURATION_MAX;
         junk = $urandom;
         write_reg(acwb_pkg::REG_ALARM_HOUR, {junk[13:0], ah[4:0]});
         write_reg(acwb_pkg::REG_ALARM_MINUTE, {junk[31:19], am[5:0]});
         write_reg(acwb_pkg::REG_ALARM_DURATION, dur[18:0]);
         junk = $urandom;
         write_reg(acwb_pkg::REG_ALARM_ENABLE, {junk[17:0], ($urandom_range(0, 4) != 0)});
         phase_end = cmds_queued + PHASE_ITEMS;
         while (cmds_queued < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               queue_alarm_match(ah, am, rand_bit());
               queue_ticks(($urandom_range(0, 9) == 0) ? $urandom_range(100, 800)
                                                        : $urandom_range(1, 40));
               if ($urandom_range(0, 3) == 0) begin
                  queue_alarm_match(ah, am, 1'b0);
                  queue_ticks($urandom_range(1, 20));
               end
               if ($urandom_range(0, 2) == 0)
                  queue_cmd(acwb_pkg::CMD_SILENCE, rand_byte(), rand_byte(), rand_bit());
            end else if (pick < 70) begin
               queue_cmd(acwb_pkg::CMD_SET, rand_byte(), rand_byte(), rand_bit());
            end else if (pick < 80) begin
               queue_cmd(acwb_pkg::CMD_SILENCE, rand_byte(), rand_byte(), rand_bit());
            end else if (pick < 90) begin
               queue_cmd(CMD_UNUSED, rand_byte(), rand_byte(), rand_bit());
            end else begin
               queue_ticks($urandom_range(1, 20));
            end
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (status_due.size() != 0) begin
         $error("%0d expected results never arrived", status_due.size());
         mismatches++;
      end
      $display("Run drove %0d commands and compared %0d results over %0d alarm settings.",
               cmds_sent, results_seen, RANDOM_PHASES + 4);
      $display("The clock model advanced %0d minutes and the alarm started %0d times.",
               minute_steps, ring_starts);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
